### rtl/assert_macros.svh
// Assertion macros used by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define RIFC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rifc check failed");
`define RIFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rifc check failed");
`else
`define RIFC_ASSERT_IMPLY(label, ante, cons)
`define RIFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/rifc_pkg.sv
package rifc_pkg;

  localparam int MASK_W     = 4;
  localparam int DEST_W     = 8;
  localparam int AGE_W      = 16;
  localparam int SLOT_W     = 8;
  localparam int STATES_W   = 8;
  localparam int INJ_RING_W = 2;
  localparam int EJ_CNT_W   = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int CORE_HEAD_BIT = 0;
  localparam int CORE_TAIL_BIT = 1;

  localparam logic [1:0] REG_STALL_SPACE = 2'd0;
  localparam logic [1:0] REG_EJ_COUNT    = 2'd1;
  localparam logic [1:0] REG_NODE_ID     = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_INJECT  = 2'd2,
    MODE_EJECT   = 2'd3
  } ring_mode_t;

  typedef struct packed {
    logic eject_cand;
    logic fwd_start;
    logic fwd_cont;
    logic inj_room;
  } lane_info_t;

  typedef struct packed {
    logic [MASK_W-1:0]     forward_mask;
    logic [MASK_W-1:0]     eject_mask;
    logic                  inject_go;
    logic [INJ_RING_W-1:0] inject_ring;
    logic [STATES_W-1:0]   ring_states;
  } step_result_t;

endpackage

### rtl/rifc_if.sv
interface rifc_in_if
  import rifc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [MASK_W-1:0]       ring_nonempty;
  logic [MASK_W-1:0]       ring_head;
  logic [MASK_W-1:0]       ring_tail;
  logic [MASK_W-1:0]       ring_full;
  logic [4*DEST_W-1:0]     ring_dest;
  logic [4*AGE_W-1:0]      ring_age;
  logic [4*SLOT_W-1:0]     ring_free_slots;
  logic                    core_valid;
  logic [1:0]              core_flags;
  logic [MASK_W-1:0]       core_ring_mask;
  logic [SLOT_W-1:0]       core_packet_size;

  modport source (
    output valid, ring_nonempty, ring_head, ring_tail, ring_full, ring_dest, ring_age,
           ring_free_slots, core_valid, core_flags, core_ring_mask, core_packet_size,
    input  ready
  );
  modport sink (
    input  valid, ring_nonempty, ring_head, ring_tail, ring_full, ring_dest, ring_age,
           ring_free_slots, core_valid, core_flags, core_ring_mask, core_packet_size,
    output ready
  );
endinterface

interface rifc_out_if
  import rifc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [MASK_W-1:0]     forward_mask;
  logic [MASK_W-1:0]     eject_mask;
  logic                  inject_go;
  logic [INJ_RING_W-1:0] inject_ring;
  logic [STATES_W-1:0]   ring_states;

  modport source (
    output valid, forward_mask, eject_mask, inject_go, inject_ring, ring_states,
    input  ready
  );
  modport sink (
    input  valid, forward_mask, eject_mask, inject_go, inject_ring, ring_states,
    output ready
  );
endinterface

### rtl/rifc_lane.sv
module rifc_lane
  import rifc_pkg::*;
(
  input  ring_mode_t        mode,
  input  logic              nonempty,
  input  logic              head,
  input  logic              full,
  input  logic [DEST_W-1:0] dest,
  input  logic [SLOT_W-1:0] free_slots,
  input  logic [DEST_W-1:0] node_id,
  input  logic [SLOT_W-1:0] packet_size,
  input  logic              stall_space,
  output lane_info_t        info
);

  logic hit;
  logic idle;

  assign hit  = (dest == node_id);
  assign idle = (mode == MODE_IDLE);

  assign info.eject_cand = idle & nonempty & head & hit;
  assign info.fwd_start  = idle & nonempty & (~hit | full);
  assign info.fwd_cont   = (mode == MODE_FORWARD) & nonempty;
  assign info.inj_room   = ~nonempty | (stall_space & (free_slots >= packet_size));

endmodule

### rtl/rifc_merge.sv
module rifc_merge
  import rifc_pkg::*;
#(
  parameter int RINGS    = 4,
  parameter int EJECTORS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  lane_info_t          lane_info [RINGS],
  input  logic [AGE_W-1:0]    age [RINGS],
  input  logic [RINGS-1:0]    nonempty,
  input  logic [RINGS-1:0]    tail,
  input  logic                core_valid,
  input  logic [1:0]          core_flags,
  input  logic [RINGS-1:0]    core_mask,
  input  logic [EJ_CNT_W-1:0] ej_count,
  output ring_mode_t          ring_mode [RINGS],
  output step_result_t        result
);

  localparam int RW     = $clog2(RINGS);
  localparam int EJ_LIM = (EJECTORS < RINGS) ? EJECTORS : RINGS;

  ring_mode_t            mode_r     [RINGS];
  ring_mode_t            mode_nxt   [RINGS];
  logic [EJECTORS-1:0]   ej_busy_r;
  logic [EJECTORS-1:0]   ej_busy_nxt;
  logic [RW-1:0]         ej_ring_r   [EJECTORS];
  logic [RW-1:0]         ej_ring_nxt [EJECTORS];
  logic                  inj_busy_r;
  logic                  inj_busy_nxt;
  logic [RW-1:0]         inj_ring_r;
  logic [RW-1:0]         inj_ring_nxt;

  logic                  beats [RINGS][RINGS];
  logic [EJECTORS-1:0]   ej_en;
  logic [RINGS-1:0]      cand;
  logic [RINGS-1:0]      fwd_start;
  logic [RINGS-1:0]      fwd_cont;
  logic [RINGS-1:0]      room;

  logic [RINGS-1:0]      claim;
  logic [RINGS-1:0]      elig;
  logic [RINGS-1:0]      win;
  logic [RINGS-1:0]      ej;
  logic [EJECTORS-1:0]   ej_rst;
  logic [RINGS-1:0]      ring_rst;
  logic [RINGS-1:0]      fwd_new;
  logic [RINGS-1:0]      fwd;
  logic [RINGS-1:0]      idle_after;
  logic [RINGS-1:0]      inj_cands;
  logic [RINGS-1:0]      pick;
  logic                  go;
  logic [RW-1:0]         gring;
  logic [STATES_W-1:0]   states;

  always_comb begin
    for (int r = 0; r < RINGS; r++) begin
      cand[r]      = lane_info[r].eject_cand;
      fwd_start[r] = lane_info[r].fwd_start;
      fwd_cont[r]  = lane_info[r].fwd_cont;
      room[r]      = lane_info[r].inj_room;
    end
  end

  always_comb begin
    for (int i = 0; i < RINGS; i++) begin
      for (int j = 0; j < RINGS; j++) begin
        beats[i][j] = (age[i] > age[j]) || ((age[i] == age[j]) && (i < j));
      end
    end
  end

  always_comb begin
    for (int e = 0; e < EJECTORS; e++) begin
      ej_en[e] = (e < EJ_LIM) && ({1'b0, ej_count} > 3'(e));
    end
  end

  always_comb begin
    claim       = '0;
    ej          = '0;
    ej_rst      = '0;
    ring_rst    = '0;
    elig        = '0;
    win         = '0;
    ej_busy_nxt = ej_busy_r;
    ej_ring_nxt = ej_ring_r;

    // ejection, one ejector after the other
    for (int e = 0; e < EJECTORS; e++) begin
      if (ej_en[e]) begin
        if (ej_busy_r[e]) begin
          if (nonempty[ej_ring_r[e]]) begin
            ej[ej_ring_r[e]] = 1'b1;
            if (tail[ej_ring_r[e]]) begin
              ej_rst[e]                = 1'b1;
              ring_rst[ej_ring_r[e]] = 1'b1;
            end
          end
        end else begin
          elig = cand & ~claim;
          for (int i = 0; i < RINGS; i++) begin
            win[i] = elig[i];
            for (int j = 0; j < RINGS; j++) begin
              if ((j != i) && elig[j] && !beats[i][j]) begin
                win[i] = 1'b0;
              end
            end
          end
          for (int i = 0; i < RINGS; i++) begin
            if (win[i]) begin
              claim[i]       = 1'b1;
              ej_busy_nxt[e] = 1'b1;
              ej_ring_nxt[e] = RW'(i);
              ej[i]          = 1'b1;
              if (tail[i]) begin
                ej_rst[e]   = 1'b1;
                ring_rst[i] = 1'b1;
              end
            end
          end
        end
      end
    end

    // forwarding
    for (int r = 0; r < RINGS; r++) begin
      fwd_new[r]    = fwd_start[r] & ~claim[r];
      fwd[r]        = fwd_cont[r] | fwd_new[r];
      idle_after[r] = (mode_r[r] == MODE_IDLE) & ~claim[r] & ~fwd_new[r];
      if (fwd[r] && tail[r]) begin
        ring_rst[r] = 1'b1;
      end
    end

    // injection
    go           = 1'b0;
    gring        = inj_ring_r;
    pick         = '0;
    inj_busy_nxt = inj_busy_r;
    inj_ring_nxt = inj_ring_r;
    inj_cands    = core_mask & idle_after & room;
    if (core_valid) begin
      if (inj_busy_r) begin
        go = 1'b1;
      end else if (core_flags[CORE_HEAD_BIT] && (|inj_cands)) begin
        for (int r = RINGS - 1; r >= 0; r--) begin
          if (inj_cands[r]) begin
            gring = RW'(r);
          end
        end
        go           = 1'b1;
        pick         = inj_cands & (~inj_cands + RINGS'(1));
        inj_busy_nxt = 1'b1;
        inj_ring_nxt = gring;
      end
      if (go && core_flags[CORE_TAIL_BIT]) begin
        inj_busy_nxt    = 1'b0;
        inj_ring_nxt    = '0;
        ring_rst[gring] = 1'b1;
      end
    end

    // release at the end of the step
    for (int e = 0; e < EJECTORS; e++) begin
      if (ej_rst[e]) begin
        ej_busy_nxt[e] = 1'b0;
        ej_ring_nxt[e] = '0;
      end
    end

    states = '0;
    for (int r = 0; r < RINGS; r++) begin
      mode_nxt[r] = mode_r[r];
      if (claim[r]) begin
        mode_nxt[r] = MODE_EJECT;
      end
      if (fwd_new[r]) begin
        mode_nxt[r] = MODE_FORWARD;
      end
      if (pick[r]) begin
        mode_nxt[r] = MODE_INJECT;
      end
      if (ring_rst[r]) begin
        mode_nxt[r] = MODE_IDLE;
      end
      states[2*r +: 2] = mode_nxt[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < RINGS; r++) begin
        mode_r[r] <= MODE_IDLE;
      end
      for (int e = 0; e < EJECTORS; e++) begin
        ej_ring_r[e] <= '0;
      end
      ej_busy_r  <= '0;
      inj_busy_r <= 1'b0;
      inj_ring_r <= '0;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      ej_busy_r  <= ej_busy_nxt;
      ej_ring_r  <= ej_ring_nxt;
      inj_busy_r <= inj_busy_nxt;
      inj_ring_r <= inj_ring_nxt;
    end
  end

  assign ring_mode           = mode_r;
  assign result.forward_mask = MASK_W'(fwd);
  assign result.eject_mask   = MASK_W'(ej);
  assign result.inject_go    = go;
  assign result.inject_ring  = go ? INJ_RING_W'(gring) : '0;
  assign result.ring_states  = states;

endmodule

### rtl/ring_interface_flit_controller.sv
// Latency: a beat accepted at one edge shows its result at the output from the next cycle.
// Throughput: one beat per cycle; the whole step resolves in the accept cycle across the
//   ring lanes and merge stage; an output register lets the next beat in unless stalled.
// Reset: synchronous, active low; all rings idle, ejectors and injector free,
//   stall_space_mode 0, ejector_count 1, node_id 0, output empty.
`include "assert_macros.svh"

module ring_interface_flit_controller
  import rifc_pkg::*;
#(
  parameter int RINGS    = 4,
  parameter int EJECTORS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rifc_in_if.sink               in_bus,
  rifc_out_if.source            out_bus,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic                stall_space_r;
  logic [EJ_CNT_W-1:0] ej_count_r;
  logic [DEST_W-1:0]   node_id_r;
  logic                cfg_wr;

  logic                in_fire;
  logic                out_valid_r;
  step_result_t        result_r;
  step_result_t        step_res;

  lane_info_t          lane_info [RINGS];
  logic [AGE_W-1:0]    age       [RINGS];
  ring_mode_t          ring_mode [RINGS];

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_space_r <= 1'b0;
      ej_count_r    <= EJ_CNT_W'(1);
      node_id_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_STALL_SPACE: stall_space_r <= cfg_pwdata[0];
        REG_EJ_COUNT:    ej_count_r    <= cfg_pwdata[EJ_CNT_W-1:0];
        REG_NODE_ID:     node_id_r     <= cfg_pwdata[DEST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_STALL_SPACE: cfg_prdata = CFG_DATA_W'(stall_space_r);
      REG_EJ_COUNT:    cfg_prdata = CFG_DATA_W'(ej_count_r);
      REG_NODE_ID:     cfg_prdata = CFG_DATA_W'(node_id_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // handshake
  assign in_bus.ready = ~out_valid_r | out_bus.ready;
  assign in_fire      = in_bus.valid & in_bus.ready;

  for (genvar r = 0; r < RINGS; r++) begin : g_lane
    assign age[r] = in_bus.ring_age[AGE_W*r +: AGE_W];

    rifc_lane u_lane (
      .mode        (ring_mode[r]),
      .nonempty    (in_bus.ring_nonempty[r]),
      .head        (in_bus.ring_head[r]),
      .full        (in_bus.ring_full[r]),
      .dest        (in_bus.ring_dest[DEST_W*r +: DEST_W]),
      .free_slots  (in_bus.ring_free_slots[SLOT_W*r +: SLOT_W]),
      .node_id     (node_id_r),
      .packet_size (in_bus.core_packet_size),
      .stall_space (stall_space_r),
      .info        (lane_info[r])
    );
  end

  rifc_merge #(
    .RINGS    (RINGS),
    .EJECTORS (EJECTORS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_fire),
    .lane_info  (lane_info),
    .age        (age),
    .nonempty   (in_bus.ring_nonempty[RINGS-1:0]),
    .tail       (in_bus.ring_tail[RINGS-1:0]),
    .core_valid (in_bus.core_valid),
    .core_flags (in_bus.core_flags),
    .core_mask  (in_bus.core_ring_mask[RINGS-1:0]),
    .ej_count   (ej_count_r),
    .ring_mode  (ring_mode),
    .result     (step_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= step_res;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.forward_mask = result_r.forward_mask;
  assign out_bus.eject_mask   = result_r.eject_mask;
  assign out_bus.inject_go    = result_r.inject_go;
  assign out_bus.inject_ring  = result_r.inject_ring;
  assign out_bus.ring_states  = result_r.ring_states;

  `RIFC_ASSERT_NEXT(a_fire_fills_out, in_fire, out_valid_r)
  `RIFC_ASSERT_IMPLY(a_no_overwrite, in_fire, !out_valid_r || out_bus.ready)
  `RIFC_ASSERT_IMPLY(a_fwd_ej_disjoint, in_fire, (step_res.forward_mask & step_res.eject_mask) == '0)

endmodule

### bench/ring_interface_flit_controller_tb.sv
module ring_interface_flit_controller_tb
  import rifc_pkg::*;
();

  localparam int RINGS        = 4;
  localparam int EJECTORS     = 2;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD    = 80;
  localparam int LIMIT_TIME   = 3_000_000;

  typedef struct packed {
    logic [MASK_W-1:0]       nonempty;
    logic [MASK_W-1:0]       head;
    logic [MASK_W-1:0]       tail;
    logic [MASK_W-1:0]       full;
    logic [4*DEST_W-1:0]     dest;
    logic [4*AGE_W-1:0]      age;
    logic [4*SLOT_W-1:0]     free_slots;
    logic                    core_valid;
    logic [1:0]              core_flags;
    logic [MASK_W-1:0]       core_mask;
    logic [SLOT_W-1:0]       packet_size;
  } flit_view_t;

  typedef struct {
    bit           is_write;
    logic [1:0]   reg_sel;
    logic [7:0]   reg_val;
    flit_view_t   beat;
    bit           typed;
    step_result_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rifc_in_if  in_if();
  rifc_out_if out_if();

  ring_interface_flit_controller #(
    .RINGS(RINGS),
    .EJECTORS(EJECTORS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_if),
    .out_bus(out_if),
    .cfg_psel(psel),
    .cfg_penable(penable),
    .cfg_pwrite(pwrite),
    .cfg_paddr(paddr),
    .cfg_pwdata(pwdata),
    .cfg_prdata(prdata),
    .cfg_pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lane and engine state of the node
  ring_mode_t lane_mode [RINGS];
  logic       ej_busy [EJECTORS];
  logic [1:0] ej_lane [EJECTORS];
  logic       inj_busy;
  logic [1:0] inj_lane;
  logic       cfg_stall_space;
  logic [1:0] cfg_ej_count;
  logic [7:0] cfg_node;

  step_result_t pending_steps[$];
  script_row_t  script[$];

  int src_max_gap;
  int sink_max_gap;
  bit long_hold_pending;
  int mismatches;
  int beats_checked;
  int flits_ejected;
  int flits_forwarded;
  int flits_injected;
  int settings_used;

  function automatic step_result_t predict_step(input flit_view_t v);
    step_result_t        res;
    logic [RINGS-1:0]    fwd;
    logic [RINGS-1:0]    ej;
    logic [RINGS-1:0]    lane_clr;
    logic [EJECTORS-1:0] ej_clr;
    logic                go;
    logic                inj_clr;
    logic                move;
    logic                fits;
    logic [1:0]          go_lane;
    logic [15:0]         best_age;
    int                  n_ej;
    int                  best;
    int                  r;
    fwd = '0;
    ej = '0;
    lane_clr = '0;
    ej_clr = '0;
    go = 1'b0;
    inj_clr = 1'b0;
    go_lane = '0;
    n_ej = int'(cfg_ej_count);
    if (n_ej > EJECTORS) n_ej = EJECTORS;
    if (n_ej > RINGS) n_ej = RINGS;

    for (int e = 0; e < n_ej; e++) begin
      if (ej_busy[e]) begin
        r = int'(ej_lane[e]);
        if (v.nonempty[r]) begin
          ej[r] = 1'b1;
          if (v.tail[r]) begin
            ej_clr[e] = 1'b1;
            lane_clr[r] = 1'b1;
          end
        end
      end else begin
        best = -1;
        best_age = '0;
        for (int k = 0; k < RINGS; k++) begin
          if (v.nonempty[k] && v.head[k] && v.dest[8*k +: 8] == cfg_node &&
              lane_mode[k] == MODE_IDLE && (best < 0 || v.age[16*k +: 16] > best_age)) begin
            best = k;
            best_age = v.age[16*k +: 16];
          end
        end
        if (best >= 0) begin
          lane_mode[best] = MODE_EJECT;
          ej_busy[e] = 1'b1;
          ej_lane[e] = best[1:0];
          ej[best] = 1'b1;
          if (v.tail[best]) begin
            ej_clr[e] = 1'b1;
            lane_clr[best] = 1'b1;
          end
        end
      end
    end

    for (int k = 0; k < RINGS; k++) begin
      move = 1'b0;
      if (lane_mode[k] == MODE_FORWARD) begin
        move = v.nonempty[k];
      end else if (lane_mode[k] == MODE_IDLE && v.nonempty[k] &&
                   (v.dest[8*k +: 8] != cfg_node || v.full[k])) begin
        lane_mode[k] = MODE_FORWARD;
        move = 1'b1;
      end
      if (move) begin
        fwd[k] = 1'b1;
        if (v.tail[k]) lane_clr[k] = 1'b1;
      end
    end

    if (v.core_valid) begin
      if (inj_busy) begin
        go = 1'b1;
        go_lane = inj_lane;
      end else if (v.core_flags[CORE_HEAD_BIT]) begin
        for (int k = 0; k < RINGS && !go; k++) begin
          fits = !v.nonempty[k] ||
                 (cfg_stall_space && v.free_slots[8*k +: 8] >= v.packet_size);
          if (v.core_mask[k] && lane_mode[k] == MODE_IDLE && fits) begin
            inj_busy = 1'b1;
            inj_lane = k[1:0];
            lane_mode[k] = MODE_INJECT;
            go = 1'b1;
            go_lane = k[1:0];
          end
        end
      end
      if (go && v.core_flags[CORE_TAIL_BIT]) begin
        inj_clr = 1'b1;
        lane_clr[go_lane] = 1'b1;
      end
    end

    for (int e = 0; e < EJECTORS; e++) begin
      if (ej_clr[e]) begin
        ej_busy[e] = 1'b0;
        ej_lane[e] = '0;
      end
    end
    res = '0;
    for (int k = 0; k < RINGS; k++) begin
      if (lane_clr[k]) lane_mode[k] = MODE_IDLE;
      res.ring_states[2*k +: 2] = lane_mode[k];
    end
    if (inj_clr) begin
      inj_busy = 1'b0;
      inj_lane = '0;
    end
    res.forward_mask = fwd;
    res.eject_mask = ej;
    res.inject_go = go;
    res.inject_ring = go ? go_lane : 2'd0;
    return res;
  endfunction

  function automatic flit_view_t flit(input logic [3:0] ne, hd, tl, fu,
                                      input logic [31:0] dst, input logic [63:0] ag,
                                      input logic [31:0] sl, input logic cv,
                                      input logic [1:0] fl, input logic [3:0] cm,
                                      input logic [7:0] ps);
    return {ne, hd, tl, fu, dst, ag, sl, cv, fl, cm, ps};
  endfunction

  function automatic void beat_row(input flit_view_t b, input bit typed = 1'b0,
                                   input step_result_t w = '0);
    script_row_t row;
    row = '{1'b0, 2'd0, 8'd0, b, typed, w};
    script.insert(script.size(), row);
  endfunction

  function automatic void reg_row(input logic [1:0] sel, input logic [7:0] val);
    script_row_t row;
    row = '{1'b1, sel, val, flit_view_t'('0), 1'b0, step_result_t'('0)};
    script.insert(script.size(), row);
  endfunction

  // mostly packet-shaped traffic that follows the current lane modes
  function automatic flit_view_t draw_traffic(input bit noise);
    flit_view_t v;
    bit         small_ages;
    int         pick;
    v = '0;
    if (noise) begin
      v.nonempty = 4'($urandom_range(0, 15));
      v.head = 4'($urandom_range(0, 15));
      v.tail = 4'($urandom_range(0, 15));
      v.full = 4'($urandom_range(0, 15));
      v.dest = $urandom;
      v.age = {$urandom, $urandom};
      v.free_slots = $urandom;
      v.core_valid = 1'($urandom_range(0, 1));
      v.core_flags = 2'($urandom_range(0, 3));
      v.core_mask = 4'($urandom_range(0, 15));
      v.packet_size = 8'($urandom_range(0, 255));
      return v;
    end
    small_ages = 1'($urandom_range(0, 1));
    for (int k = 0; k < RINGS; k++) begin
      v.nonempty[k] = $urandom_range(0, 9) < 7;
      if (lane_mode[k] == MODE_IDLE) begin
        v.head[k] = $urandom_range(0, 9) != 0;
        v.tail[k] = v.head[k] ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
      end else begin
        v.head[k] = $urandom_range(0, 15) == 0;
        v.tail[k] = $urandom_range(0, 3) == 0;
      end
      v.full[k] = $urandom_range(0, 4) == 0;
      v.dest[8*k +: 8] = $urandom_range(0, 1) ? cfg_node : 8'($urandom_range(0, 255));
      v.age[16*k +: 16] = small_ages ? 16'($urandom_range(0, 3))
                                     : 16'($urandom_range(0, 65535));
      v.free_slots[8*k +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 12))
                                                    : 8'($urandom_range(0, 255));
    end
    v.core_valid = $urandom_range(0, 4) != 0;
    if (inj_busy) begin
      v.core_flags[CORE_TAIL_BIT] = $urandom_range(0, 3) == 0;
      v.core_flags[CORE_HEAD_BIT] = $urandom_range(0, 15) == 0;
    end else begin
      v.core_flags[CORE_HEAD_BIT] = $urandom_range(0, 9) != 0;
      v.core_flags[CORE_TAIL_BIT] = $urandom_range(0, 9) < 4;
    end
    v.core_mask = 4'($urandom_range(0, 15));
    pick = int'($urandom_range(0, 49));
    if (pick == 0) v.packet_size = 8'd0;
    else if (pick < 10) v.packet_size = 8'($urandom_range(1, 255));
    else v.packet_size = 8'($urandom_range(1, 10));
    return v;
  endfunction

  task automatic send_beat(input flit_view_t v, input bit typed, input step_result_t want);
    int           gap;
    step_result_t predicted;
    gap = int'($urandom_range(0, src_max_gap));
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.ring_nonempty    <= v.nonempty;
    in_if.ring_head        <= v.head;
    in_if.ring_tail        <= v.tail;
    in_if.ring_full        <= v.full;
    in_if.ring_dest        <= v.dest;
    in_if.ring_age         <= v.age;
    in_if.ring_free_slots  <= v.free_slots;
    in_if.core_valid       <= v.core_valid;
    in_if.core_flags       <= v.core_flags;
    in_if.core_ring_mask   <= v.core_mask;
    in_if.core_packet_size <= v.packet_size;
    in_if.valid            <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    predicted = predict_step(v);
    pending_steps.insert(pending_steps.size(), typed ? want : predicted);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_STALL_SPACE: cfg_stall_space = val[0];
      REG_EJ_COUNT:    cfg_ej_count = val[1:0];
      REG_NODE_ID:     cfg_node = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_phase(input logic stall, input logic [1:0] ejc, input logic [7:0] node,
                           input int sgap, input int kgap, input bit hold, input int beats);
    flit_view_t v;
    settle();
    write_reg(REG_STALL_SPACE, {7'd0, stall});
    write_reg(REG_EJ_COUNT, {6'd0, ejc});
    write_reg(REG_NODE_ID, node);
    settings_used++;
    src_max_gap = sgap;
    sink_max_gap = kgap;
    long_hold_pending = hold;
    repeat (beats) begin
      v = draw_traffic($urandom_range(0, 9) == 0);
      send_beat(v, 1'b0, '0);
    end
  endtask

  // result side: draw a stall per beat, compare against the oldest prediction
  initial begin
    int           n;
    step_result_t got;
    step_result_t want;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      n = long_hold_pending ? LONG_HOLD : int'($urandom_range(0, sink_max_gap));
      long_hold_pending = 1'b0;
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got = {out_if.forward_mask, out_if.eject_mask, out_if.inject_go,
             out_if.inject_ring, out_if.ring_states};
      if (pending_steps.size() == 0) begin
        $error("result beat arrived with no prediction waiting");
        mismatches++;
      end else begin
        want = pending_steps[0];
        pending_steps.delete(0);
        beats_checked++;
        flits_ejected += $countones(got.eject_mask);
        flits_forwarded += $countones(got.forward_mask);
        flits_injected += int'(got.inject_go);
        if (got.forward_mask !== want.forward_mask) begin
          $error("forward_mask: expected %h, got %h", want.forward_mask, got.forward_mask);
          mismatches++;
        end
        if (got.eject_mask !== want.eject_mask) begin
          $error("eject_mask: expected %h, got %h", want.eject_mask, got.eject_mask);
          mismatches++;
        end
        if (got.inject_go !== want.inject_go) begin
          $error("inject_go: expected %h, got %h", want.inject_go, got.inject_go);
          mismatches++;
        end
        if (got.inject_ring !== want.inject_ring) begin
          $error("inject_ring: expected %h, got %h", want.inject_ring, got.inject_ring);
          mismatches++;
        end
        if (got.ring_states !== want.ring_states) begin
          $error("ring_states: expected %h, got %h", want.ring_states, got.ring_states);
          mismatches++;
        end
      end
    end
  end

  initial begin
    script_row_t row;
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    in_if.valid            <= 1'b0;
    in_if.ring_nonempty    <= '0;
    in_if.ring_head        <= '0;
    in_if.ring_tail        <= '0;
    in_if.ring_full        <= '0;
    in_if.ring_dest        <= '0;
    in_if.ring_age         <= '0;
    in_if.ring_free_slots  <= '0;
    in_if.core_valid       <= 1'b0;
    in_if.core_flags       <= '0;
    in_if.core_ring_mask   <= '0;
    in_if.core_packet_size <= 8'd1;
    for (int k = 0; k < RINGS; k++) lane_mode[k] = MODE_IDLE;
    for (int e = 0; e < EJECTORS; e++) begin
      ej_busy[e] = 1'b0;
      ej_lane[e] = '0;
    end
    inj_busy = 1'b0;
    inj_lane = '0;
    cfg_stall_space = 1'b0;
    cfg_ej_count = 2'd1;
    cfg_node = 8'd0;
    src_max_gap = 3;
    sink_max_gap = 3;
    long_hold_pending = 1'b0;
    mismatches = 0;
    beats_checked = 0;
    flits_ejected = 0;
    flits_forwarded = 0;
    flits_injected = 0;
    settings_used = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1),
             1'b1, {4'h0, 4'h0, 1'b0, 2'd0, 8'h00});
    beat_row(flit(4'hF, 4'hF, 4'hF, 4'hF, '1, '1, '1, 1'b1, 2'b11, 4'hF, 8'hFF),
             1'b1, {4'hF, 4'h0, 1'b0, 2'd0, 8'h00});
    beat_row(flit(4'h4, 4'h4, 4'h4, 4'h0, 32'h0, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1),
             1'b1, {4'h0, 4'h4, 1'b0, 2'd0, 8'h00});
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b1, 2'b11, 4'h1, 8'd1),
             1'b1, {4'h0, 4'h0, 1'b1, 2'd0, 8'h00});
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b1, 2'b01, 4'h8, 8'd4),
             1'b1, {4'h0, 4'h0, 1'b1, 2'd3, 8'h80});
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b1, 2'b00, 4'h8, 8'd4),
             1'b1, {4'h0, 4'h0, 1'b1, 2'd3, 8'h80});
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b1, 2'b01, 4'h1, 8'd4),
             1'b1, {4'h0, 4'h0, 1'b1, 2'd3, 8'h80});
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b1, 2'b10, 4'h1, 8'd4),
             1'b1, {4'h0, 4'h0, 1'b1, 2'd3, 8'h00});
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b1, 2'b00, 4'hF, 8'd4),
             1'b1, {4'h0, 4'h0, 1'b0, 2'd0, 8'h00});
    beat_row(flit(4'h3, 4'h3, 4'h0, 4'h0, 32'hFFFF0000, 64'h0000_0000_0005_0005, 32'h0,
                  1'b0, 2'b00, 4'h0, 8'd1), 1'b1, {4'h0, 4'h1, 1'b0, 2'd0, 8'h03});
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'hFFFF0000, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1),
             1'b1, {4'h0, 4'h0, 1'b0, 2'd0, 8'h03});
    beat_row(flit(4'h2, 4'h2, 4'h2, 4'h2, 32'h0, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1));
    beat_row(flit(4'h1, 4'h1, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1));
    beat_row(flit(4'h1, 4'h0, 4'h1, 4'h0, 32'h0, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1),
             1'b1, {4'h0, 4'h1, 1'b0, 2'd0, 8'h00});
    beat_row(flit(4'hA, 4'hA, 4'h0, 4'h0, 32'h0, 64'h0009_0000_0005_0000, 32'h0,
                  1'b0, 2'b00, 4'h0, 8'd1));
    beat_row(flit(4'h1, 4'h0, 4'h0, 4'h0, 32'h000000FF, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1));
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b1, 2'b01, 4'h3, 8'd1));
    beat_row(flit(4'h9, 4'h0, 4'h9, 4'h0, 32'h000000FF, 64'h0, 32'h0, 1'b1, 2'b10, 4'h0, 8'd1));
    reg_row(REG_STALL_SPACE, 8'd1);
    reg_row(REG_EJ_COUNT, 8'd2);
    reg_row(REG_NODE_ID, 8'hA5);
    beat_row(flit(4'h1, 4'h0, 4'h0, 4'h0, 32'h000000A5, 64'h0, 32'h0, 1'b1, 2'b01, 4'h1, 8'd0));
    beat_row(flit(4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 64'h0, 32'h0, 1'b1, 2'b10, 4'h1, 8'd1));
    reg_row(REG_EJ_COUNT, 8'd0);
    beat_row(flit(4'h1, 4'h1, 4'h1, 4'h0, 32'h000000A5, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1),
             1'b1, {4'h0, 4'h0, 1'b0, 2'd0, 8'h00});
    reg_row(REG_EJ_COUNT, 8'd3);
    beat_row(flit(4'h5, 4'h5, 4'h5, 4'h0, 32'h00A500A5, 64'h0, 32'h0, 1'b0, 2'b00, 4'h0, 8'd1),
             1'b1, {4'h0, 4'h5, 1'b0, 2'd0, 8'h00});

    foreach (script[i]) begin
      row = script[i];
      if (row.is_write) begin
        settle();
        write_reg(row.reg_sel, row.reg_val);
        settings_used++;
      end else begin
        send_beat(row.beat, row.typed, row.want);
      end
    end

    run_phase(1'b0, 2'd1, 8'd0, 0, 0, 1'b0, 100);
    run_phase(1'b1, 2'd2, 8'hFF, 18, 18, 1'b0, 100);
    run_phase(1'b1, 2'd2, 8'($urandom_range(0, 255)), 0, 0, 1'b1, 100);
    run_phase(1'b0, 2'd0, 8'($urandom_range(0, 255)), 5, 18, 1'b0, 80);
    run_phase(1'b1, 2'd3, 8'($urandom_range(0, 255)), 18, 0, 1'b0, 100);
    run_phase(1'b0, 2'd2, 8'($urandom_range(0, 255)), 18, 18, 1'b0, 120);
    run_phase(1'b1, 2'd1, 8'd0, 3, 3, 1'b0, 100);
    run_phase(1'b1, 2'd2, 8'($urandom_range(0, 255)), 0, 18, 1'b0, 100);
    settle();

    $display("Checked %0d result beats across %0d register settings.",
             beats_checked, settings_used);
    $display("Flits moved: %0d ejected, %0d forwarded, %0d injected.",
             flits_ejected, flits_forwarded, flits_injected);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(LIMIT_TIME);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
